[hw/rtl/stream_population_variance_macros.svh]
// Assertion helpers; clk and rst_n are taken from the enclosing module.
`ifndef STREAM_POPULATION_VARIANCE_MACROS_SVH
`define STREAM_POPULATION_VARIANCE_MACROS_SVH

`ifndef SYNTHESIS
`define SVP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SVP_NEVER(lbl, cond, msg) \
    `SVP_ASSERT(lbl, !(cond), msg)
`else
`define SVP_ASSERT(lbl, prop, msg)
`define SVP_NEVER(lbl, cond, msg)
`endif

`endif

[hw/rtl/svp_pkg.sv]
`timescale 1ns / 1ps

package svp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 17;
    localparam int SUM_W      = 33;
    localparam int SQSUM_W    = 47;
    localparam int VAR_W      = 38;
    localparam int MAG_W      = 32;
    localparam int DEN_W      = 33;
    localparam int NUM_W      = 64;
    localparam int SQ_SPLIT   = 24;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_FEW = 2'd1,
        STATUS_OVF = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } item_t;

    typedef struct packed {
        logic [VAR_W-1:0] variance;
        status_t          status;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0]        n;
        logic signed [SUM_W-1:0]   sum;
        logic [SQSUM_W-1:0]        sqsum;
        status_t                   status;
    } job_t;

endpackage

[hw/rtl/stream_population_variance.sv]
`timescale 1ns / 1ps
// channel   direction  handshake                     payload
// item      in         item_valid / item_ready        item_t   {sample, last}
// result    out        result_valid / result_ready    result_t {variance, status}
//
// Samples are taken one per cycle; a sample marked last stalls only while the
// two-deep job queue between accumulator and divider is full.
// The divider steps through multiply-low, multiply-high and combine, then the restoring
// division at one quotient bit per cycle, then output; it takes a new job only when idle.
// A set of fewer than two samples or past the count limit skips the multiplies and division.
// Reset clears the accumulators, the queue and the result register at once.
// A result waiting on result_ready holds the divider but not the accumulator.

module stream_population_variance
    import svp_pkg::*;
#(
    parameter int MAX_COUNT = 65536,
    parameter int FRAC_BITS = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic front_valid, front_ready;
    job_t front_job;
    logic back_valid, back_ready;
    job_t back_job;

    svp_front #(
        .MAX_COUNT(MAX_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .job_valid  (front_valid),
        .job_ready  (front_ready),
        .job        (front_job)
    );

    svp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_job    (front_job),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_job   (back_job)
    );

    svp_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (back_valid),
        .job_ready    (back_ready),
        .job          (back_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[hw/rtl/svp_front.sv]
`timescale 1ns / 1ps

module svp_front
    import svp_pkg::*;
#(
    parameter int MAX_COUNT = 65536
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    output logic  job_valid,
    input  logic  job_ready,
    output job_t  job
);

    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_COUNT);
    localparam logic [COUNT_W-1:0] MIN_CNT = COUNT_W'(2);

    logic [COUNT_W-1:0]      count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQSUM_W-1:0]      sqsum_reg, sqsum_next;
    logic                    ovf_reg, ovf_next;
    logic                    room;
    logic                    take;
    logic signed [31:0]      square;
    status_t                 status;

    assign take       = item_valid && item_ready;
    assign item_ready = !item.last || job_ready;
    assign job_valid  = item_valid && item.last;
    assign room       = count_reg < MAX_CNT;
    assign square     = item.sample * item.sample;

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sqsum_next = sqsum_reg;
        ovf_next   = ovf_reg;
        if (room)
        begin
            count_next = count_reg + COUNT_W'(1);
            sum_next   = sum_reg + SUM_W'(item.sample);
            sqsum_next = sqsum_reg + SQSUM_W'(unsigned'(square));
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    always_comb
    begin
        priority if (ovf_next)
            status = STATUS_OVF;
        else if (count_next < MIN_CNT)
            status = STATUS_FEW;
        else
            status = STATUS_OK;
    end

    assign job = '{n: count_next, sum: sum_next, sqsum: sqsum_next, status: status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (take)
        begin
            if (item.last)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                sqsum_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                sqsum_reg <= sqsum_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

[hw/rtl/svp_queue.sv]
`timescale 1ns / 1ps

module svp_queue
    import svp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready  = count_reg != FULL;
    assign out_valid = count_reg != '0;
    assign out_job   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

[hw/rtl/svp_back.sv]
`timescale 1ns / 1ps
`include "stream_population_variance_macros.svh"

module svp_back
    import svp_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    output logic    job_ready,
    input  job_t    job,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int DIV_W = NUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);
    localparam int LO_W = COUNT_W + SQ_SPLIT;
    localparam int HI_W = COUNT_W + SQSUM_W - SQ_SPLIT;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_COMBINE,
        S_DIV,
        S_OUT
    } state_t;

    state_t             state_reg;
    logic [COUNT_W-1:0] n_reg;
    logic [SQSUM_W-1:0] sqsum_reg;
    logic [MAG_W-1:0]   mag_reg;
    status_t            status_reg;
    logic [LO_W-1:0]    prod_lo_reg;
    logic [HI_W-1:0]    prod_hi_reg;
    logic [NUM_W-1:0]   mag2_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DIV_W-1:0]   dividend_reg;
    logic [DIV_W-1:0]   quot_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    logic [NUM_W-1:0]         num;
    logic [DEN_W:0]           trial;
    logic [DEN_W:0]           diff;
    logic                     fits;
    logic                     saturate;
    logic signed [SUM_W-1:0]  abs_sum;
    logic                     out_free;

    assign job_ready    = state_reg == S_IDLE;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || result_ready;

    assign abs_sum  = job.sum[SUM_W-1] ? -job.sum : job.sum;
    assign num      = {prod_hi_reg, SQ_SPLIT'(0)} + NUM_W'(prod_lo_reg) - mag2_reg;
    assign trial    = {rem_reg, dividend_reg[DIV_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign fits     = !diff[DEN_W];
    assign saturate = |quot_reg[DIV_W-1:VAR_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            n_reg            <= '0;
            sqsum_reg        <= '0;
            mag_reg          <= '0;
            status_reg       <= STATUS_OK;
            prod_lo_reg      <= '0;
            prod_hi_reg      <= '0;
            mag2_reg         <= '0;
            den_reg          <= '0;
            dividend_reg     <= '0;
            quot_reg         <= '0;
            rem_reg          <= '0;
            cnt_reg          <= '0;
        end
        else
        begin
            if (result_valid_reg && result_ready && (state_reg != S_OUT))
                result_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        n_reg      <= job.n;
                        sqsum_reg  <= job.sqsum;
                        mag_reg    <= MAG_W'(abs_sum);
                        status_reg <= job.status;
                        state_reg  <= (job.status == STATUS_OK) ? S_MUL_LO : S_OUT;
                    end
                end
                S_MUL_LO:
                begin
                    prod_lo_reg <= LO_W'(n_reg) * LO_W'(sqsum_reg[SQ_SPLIT-1:0]);
                    den_reg     <= DEN_W'(n_reg) * DEN_W'(n_reg);
                    state_reg   <= S_MUL_HI;
                end
                S_MUL_HI:
                begin
                    prod_hi_reg <= HI_W'(n_reg) * HI_W'(sqsum_reg[SQSUM_W-1:SQ_SPLIT]);
                    mag2_reg    <= NUM_W'(mag_reg) * NUM_W'(mag_reg);
                    state_reg   <= S_COMBINE;
                end
                S_COMBINE:
                begin
                    dividend_reg <= DIV_W'(num) << FRAC_BITS;
                    quot_reg     <= '0;
                    rem_reg      <= '0;
                    cnt_reg      <= CNT_LAST;
                    state_reg    <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg      <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    quot_reg     <= {quot_reg[DIV_W-2:0], fits};
                    dividend_reg <= {dividend_reg[DIV_W-2:0], 1'b0};
                    cnt_reg      <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        result_valid_reg  <= 1'b1;
                        result_reg.status <= status_reg;
                        if (status_reg != STATUS_OK)
                            result_reg.variance <= '0;
                        else if (saturate)
                            result_reg.variance <= '1;
                        else
                            result_reg.variance <= quot_reg[VAR_W-1:0];
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `SVP_ASSERT(a_rem_below_den, (state_reg == S_DIV) |-> (rem_reg < den_reg), "remainder too big")
    `SVP_ASSERT(a_result_from_out, $rose(result_valid_reg) |-> $past(state_reg == S_OUT), "stray result")
    `SVP_NEVER(a_non_ok_zero, (result_reg.status != STATUS_OK) && (result_reg.variance != '0), "bad variance")

endmodule
